// ----- rtl/core/dlcg_pkg.sv -----
// ============================================================================
// dlcg_pkg
// Shared constants, register indexes and the tanh table for the growl block.
// ============================================================================
package dlcg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DELAY_DEPTH = 4096;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int DLEN_W      = 12;
    localparam int ALPHA_W     = 16;
    localparam int BETA_W      = 16;
    localparam int CFG_IDX_W   = 2;

    // Largest blend value (1.0 in Q1.15)
    localparam logic [BETA_W:0] BETA_ONE = 17'd32768;

    // Table positions at or above this saturate
    localparam int TANH_LAST = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROWL_ENABLE = 2'd0,
        REG_GROWL_ALPHA  = 2'd1,
        REG_GROWL_BETA   = 2'd2,
        REG_DELAY_LENGTH = 2'd3
    } cfg_reg_t;

    // round(32768*tanh(k/8)), last entry pinned to full scale
    function automatic logic [14:0] tanh_entry(input logic [5:0] k);
        logic [14:0] v;
        unique case (k)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd4075;
            6'd2:  v = 15'd8025;
            6'd3:  v = 15'd11743;
            6'd4:  v = 15'd15143;
            6'd5:  v = 15'd18173;
            6'd6:  v = 15'd20813;
            6'd7:  v = 15'd23066;
            6'd8:  v = 15'd24956;
            6'd9:  v = 15'd26519;
            6'd10: v = 15'd27797;
            6'd11: v = 15'd28830;
            6'd12: v = 15'd29660;
            6'd13: v = 15'd30322;
            6'd14: v = 15'd30847;
            6'd15: v = 15'd31262;
            6'd16: v = 15'd31589;
            6'd17: v = 15'd31846;
            6'd18: v = 15'd32048;
            6'd19: v = 15'd32206;
            6'd20: v = 15'd32329;
            6'd21: v = 15'd32426;
            6'd22: v = 15'd32501;
            6'd23: v = 15'd32560;
            6'd24: v = 15'd32606;
            6'd25: v = 15'd32642;
            6'd26: v = 15'd32670;
            6'd27: v = 15'd32691;
            6'd28: v = 15'd32708;
            6'd29: v = 15'd32721;
            6'd30: v = 15'd32732;
            6'd31: v = 15'd32740;
            6'd32: v = 15'd32746;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/delay_line_chaos_growl.sv -----
// ============================================================================
// delay_line_chaos_growl
// Chaotic delay-line growl: tanh(x + beta*alpha*x_delayed*|x|) on Q1.15 audio.
// ============================================================================
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ---------------------------------
//  s_*       in         s_tvalid/s_tready  s_tdata[15:0]  sample_in
//  m_*       out        m_tvalid/m_tready  m_tdata[15:0]  sample_out
//  cfg_*     in         cfg_valid/ready    cfg_index[1:0], cfg_data[15:0]
//
//  Flow: one item in flight; an accepted item steps through S_READ, S_MUL,
//  S_SUM, S_MAG, S_INTERP and S_FIN to the output register; the next item
//  is accepted once the state is back in S_IDLE. Those steps hold two
//  registered multiplies, the wide sum, the magnitude and the interpolation.
//  Reset: config registers to their defaults, pointer to zero. The delay memory is
//  not swept; a wrap flag plus the write pointer mark which entries have been
//  written, and unwritten entries read as zero. No clearing pass.
//  Stalls: a finished item waits in the output register while the next item
//  is accepted; if it is still waiting when the next result is done, the
//  datapath holds in its final step. cfg_ready is always high.
//
module delay_line_chaos_growl (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dlcg_pkg::SAMPLE_BITS-1:0]  s_tdata,   // [15:0] sample_in
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dlcg_pkg::SAMPLE_BITS-1:0]  m_tdata,   // [15:0] sample_out
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlcg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);
    import dlcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_MAG,
        S_INTERP,
        S_FIN
    } state_t;

    // ---------------------------------------------------------------- config
    logic                      growl_enable_reg;
    logic signed [ALPHA_W-1:0] growl_alpha_reg;
    logic [BETA_W-1:0]         growl_beta_reg;
    logic [DLEN_W-1:0]         delay_length_reg;

    logic cfg_fire;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            growl_enable_reg <= 1'b0;
            growl_alpha_reg  <= '0;
            growl_beta_reg   <= '0;
            delay_length_reg <= DLEN_W'(240);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GROWL_ENABLE: growl_enable_reg <= cfg_data[0];
                REG_GROWL_ALPHA:  growl_alpha_reg  <= $signed(cfg_data[ALPHA_W-1:0]);
                REG_GROWL_BETA:   growl_beta_reg   <= cfg_data[BETA_W-1:0];
                REG_DELAY_LENGTH: delay_length_reg <= cfg_data[DLEN_W-1:0];
            endcase
        end
    end

    // alpha*beta gain, Q27, recomputed every cycle from the static config
    logic [BETA_W:0]    beta_sat;
    logic signed [31:0] ab_reg;
    logic signed [33:0] ab_full;

    assign beta_sat = ({1'b0, growl_beta_reg} > BETA_ONE) ? BETA_ONE : {1'b0, growl_beta_reg};
    assign ab_full  = growl_alpha_reg * $signed({1'b0, beta_sat});

    always_ff @(posedge clk)
    begin
        ab_reg <= ab_full[31:0];
    end

    // ------------------------------------------------------- pointer / fill
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg;
    logic              wrapped_reg;   // every entry written at least once
    logic              accept;
    logic [DLEN_W-1:0] dl_clamped;
    logic [PTR_W-1:0]  dl_ptr;
    logic [PTR_W-1:0]  rd_addr;
    logic              rd_written;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        priority if (delay_length_reg == '0)
            dl_clamped = DLEN_W'(1);
        else if (32'(delay_length_reg) > DELAY_DEPTH - 1)
            dl_clamped = DLEN_W'(DELAY_DEPTH - 1);
        else
            dl_clamped = delay_length_reg;
    end

    assign dl_ptr = PTR_W'(dl_clamped);
    assign rd_addr = (wp_reg >= dl_ptr) ? PTR_W'(wp_reg - dl_ptr)
                                        : PTR_W'(32'(wp_reg) + DELAY_DEPTH - 32'(dl_ptr));
    assign rd_written = wrapped_reg | (rd_addr < wp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept && growl_enable_reg)
        begin
            if (32'(wp_reg) == DELAY_DEPTH - 1)
            begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + PTR_W'(1);
            end
        end
    end

    // ---------------------------------------------------------- delay memory
    logic [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (accept && growl_enable_reg)
        begin
            delay_mem[wp_reg] <= s_tdata;
        end
        rdata_reg <= delay_mem[rd_addr];
    end

    // -------------------------------------------------------------- datapath
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          en_reg;
    logic                          rd_ok_reg;
    logic signed [31:0]            p1_reg;      // xd*|x|, Q30
    logic signed [63:0]            prod_reg;    // Q57
    logic signed [63:0]            sum_reg;
    logic                          neg_reg;
    logic                          sat_reg;
    logic [5:0]                    k_reg;
    logic [15:0]                   frac_reg;
    logic [27:0]                   dfrac_reg;

    logic signed [SAMPLE_BITS-1:0] xd;
    logic [SAMPLE_BITS:0]          ax;
    logic signed [34:0]            p1_full;
    logic [62:0]                   mag;
    logic [8:0]                    k_full;
    logic [14:0]                   t_lo;
    logic [14:0]                   t_hi;
    logic [11:0]                   t_diff;
    logic [12:0]                   interp;
    logic [14:0]                   y_mag;
    logic [SAMPLE_BITS-1:0]        y_out;
    logic                          out_load;

    assign xd      = rd_ok_reg ? $signed(rdata_reg) : '0;
    assign ax      = x_reg[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-32'(x_reg))
                                          : (SAMPLE_BITS+1)'(x_reg);
    assign p1_full = xd * $signed({1'b0, ax});

    assign mag    = sum_reg[63] ? 63'(-sum_reg) : sum_reg[62:0];
    assign k_full = mag[62:54];

    assign t_lo   = tanh_entry(k_reg);
    assign t_hi   = tanh_entry(k_reg + 6'd1);
    assign t_diff = 12'(t_hi - t_lo);

    assign interp = 13'((29'(dfrac_reg) + 29'd32768) >> 16);
    assign y_mag  = sat_reg ? 15'd32767 : 15'(t_lo + 15'(interp));
    assign y_out  = neg_reg ? SAMPLE_BITS'(-$signed({1'b0, y_mag}))
                            : SAMPLE_BITS'({1'b0, y_mag});

    assign out_load = (state_reg == S_FIN) && (!m_tvalid || m_tready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= $signed(s_tdata);
            en_reg    <= growl_enable_reg;
            rd_ok_reg <= rd_written;
        end
        if (state_reg == S_READ)
        begin
            p1_reg <= p1_full[31:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= p1_reg * ab_reg;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= prod_reg + $signed({{6{x_reg[SAMPLE_BITS-1]}}, x_reg, 42'd0});
        end
        if (state_reg == S_MAG)
        begin
            neg_reg  <= sum_reg[63];
            sat_reg  <= (k_full >= 9'(TANH_LAST));
            k_reg    <= k_full[5:0];
            frac_reg <= mag[53:38];
        end
        if (state_reg == S_INTERP)
        begin
            dfrac_reg <= t_diff * frac_reg;
        end
    end

    // --------------------------------------------------------- control + out
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_READ;
            S_READ:   state_next = S_MUL;
            S_MUL:    state_next = S_SUM;
            S_SUM:    state_next = S_MAG;
            S_MAG:    state_next = S_INTERP;
            S_INTERP: state_next = S_FIN;
            S_FIN:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= en_reg ? y_out : x_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------ assertions
    // one item in flight: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a bypassed item leaves the write pointer alone
    a_bypass_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !growl_enable_reg) |=> $stable(wp_reg) && $stable(wrapped_reg))
        else $error("write pointer moved on a bypassed item");

    // the delayed read never targets the entry being written
    a_rd_ne_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && growl_enable_reg) |-> (rd_addr != wp_reg))
        else $error("delay read collides with write");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result lost");

endmodule

// ----- sim/delay_line_chaos_growl_test.sv -----
// ============================================================================
// delay_line_chaos_growl_test
// Self-checking bench for the chaotic delay-line growl. Samples stream in
// through s_*, each growled result is compared against a bit-exact predictor
// kept in the bench. A directed table runs first, then randomized setting
// phases with bursty back-pressure on both sides, then a closing run with no
// idling at the longest delay and at a short one.
// ============================================================================
module delay_line_chaos_growl_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dlcg_pkg::*;

    // no transfer of any kind for this many cycles means the block is stuck
    localparam int STUCK_LIMIT = 2000;
    // cycles to keep watching once the last result is in
    localparam int DRAIN_CYCLES = 24;
    // random part: samples spread over setting phases
    localparam int RANDOM_ITEMS = 1000;

    // directed table columns
    localparam bit SMP   = 1'b0;
    localparam bit CFG   = 1'b1;
    localparam bit TYPED = 1'b1;
    localparam bit CALC  = 1'b0;

    typedef struct packed {
        bit          is_cfg;    // register write instead of a sample
        cfg_reg_t    reg_id;    // register for write rows
        logic [15:0] value;     // sample or register data
        bit          typed;     // result given below, not predicted
        logic [15:0] want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SAMPLE_BITS-1:0]  s_tdata;   // [15:0] sample_in
    logic                    m_tvalid;
    logic                    m_tready;
    logic [SAMPLE_BITS-1:0]  m_tdata;   // [15:0] sample_out
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_reg_t                cfg_index;
    logic [15:0]             cfg_data;

    // ------------------------------------------------------------------------
    // Predictor state: shadow registers plus our own copy of the delay memory
    // ------------------------------------------------------------------------
    logic [15:0]      echo_mem [0:DELAY_DEPTH-1];
    logic [PTR_W-1:0] echo_wptr;
    bit               sh_enable;
    logic [15:0]      sh_alpha;
    logic [15:0]      sh_beta;
    logic [DLEN_W-1:0] sh_delay;

    // round(32768*tanh(k/8)), k = 0..32, then full scale
    int tanh_curve [0:33] = '{
        0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
        24956, 26519, 27797, 28830, 29660, 30322, 30847, 31262,
        31589, 31846, 32048, 32206, 32329, 32426, 32501, 32560,
        32606, 32642, 32670, 32691, 32708, 32721, 32732, 32740,
        32746, 32767
    };

    // growled samples still owed by the block, oldest first
    logic [15:0] growled_due [$];

    int send_gap_pct;
    int sink_stall_pct;
    int stall_left;
    int idle_cycles;
    int fails;
    int n_sent;
    int n_checked;
    int n_writes;
    int n_wraps;
    int n_random;
    int phase_len;
    logic [15:0] got_want;

    // ------------------------------------------------------------------------
    // Directed table: pass-through first (reset state), then delay of one so
    // each sample meets the previous one, driving the sum hard into the
    // saturated end of the curve, then the clamp and masking corners.
    // ------------------------------------------------------------------------
    plan_row_t directed_plan [0:36] = '{
        // growl off after reset: samples come back untouched
        '{SMP, REG_GROWL_ENABLE, 16'h0000, TYPED, 16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h7FFF, TYPED, 16'h7FFF},
        '{SMP, REG_GROWL_ENABLE, 16'h8000, TYPED, 16'h8000},
        '{SMP, REG_GROWL_ENABLE, 16'hFFFF, TYPED, 16'hFFFF},
        '{SMP, REG_GROWL_ENABLE, 16'h0001, TYPED, 16'h0001},
        '{SMP, REG_GROWL_ENABLE, 16'hAAAA, TYPED, 16'hAAAA},
        '{SMP, REG_GROWL_ENABLE, 16'h5555, TYPED, 16'h5555},
        // max gain, full wet, one-sample delay
        '{CFG, REG_GROWL_ALPHA,  16'h7FFF, CALC,  16'h0000},
        '{CFG, REG_GROWL_BETA,   16'h8000, CALC,  16'h0000},
        '{CFG, REG_DELAY_LENGTH, 16'h0001, CALC,  16'h0000},
        '{CFG, REG_GROWL_ENABLE, 16'h0001, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h0000, TYPED, 16'h0000},   // zero in, zero out
        '{SMP, REG_GROWL_ENABLE, 16'h8000, CALC,  16'h0000},   // tanh(-1), zero delayed
        '{SMP, REG_GROWL_ENABLE, 16'h8000, TYPED, 16'h8001},   // negative rail
        '{SMP, REG_GROWL_ENABLE, 16'h7FFF, TYPED, 16'h8001},   // delayed term wins
        '{SMP, REG_GROWL_ENABLE, 16'h7FFF, TYPED, 16'h7FFF},   // positive rail
        // most negative gain, blend above one (saturates to 1.0)
        '{CFG, REG_GROWL_ALPHA,  16'h8000, CALC,  16'h0000},
        '{CFG, REG_GROWL_BETA,   16'hFFFF, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h7FFF, TYPED, 16'h8001},
        '{SMP, REG_GROWL_ENABLE, 16'hFFFF, CALC,  16'h0000},
        // zero delay clamps to one
        '{CFG, REG_DELAY_LENGTH, 16'h0000, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h3039, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'hCFC7, CALC,  16'h0000},
        // longest delay, upper data bits dropped by the 12-bit register
        '{CFG, REG_DELAY_LENGTH, 16'hFFFF, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h0064, CALC,  16'h0000},
        // dry blend: plain tanh of the input
        '{CFG, REG_GROWL_BETA,   16'h0000, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h4000, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'hC000, CALC,  16'h0000},
        '{CFG, REG_GROWL_ALPHA,  16'h0000, CALC,  16'h0000},
        '{CFG, REG_GROWL_BETA,   16'h8000, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h1234, CALC,  16'h0000},
        // enable bit low with junk above it: growl off, store left alone
        '{CFG, REG_GROWL_ENABLE, 16'hFFFE, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h8000, TYPED, 16'h8000},
        '{SMP, REG_GROWL_ENABLE, 16'h0000, TYPED, 16'h0000},
        '{CFG, REG_GROWL_ENABLE, 16'h0001, CALC,  16'h0000},
        '{CFG, REG_DELAY_LENGTH, 16'hF003, CALC,  16'h0000},
        '{SMP, REG_GROWL_ENABLE, 16'h7FFF, CALC,  16'h0000}
    };

    delay_line_chaos_growl uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------------
    // Growl predictor: one accepted sample in, the expected output back.
    // Sum is x + beta*alpha*xd*|x| in Q57, exact in 64 bits; the magnitude
    // indexes the tanh curve in steps of 1/8 with a 16-bit fraction.
    // ------------------------------------------------------------------------
    function automatic logic [15:0] growl_sample(input logic [15:0] raw);
        longint x;
        longint xd;
        longint ax;
        longint wet;
        longint acc;
        longint unsigned mag;
        int dl;
        int rd;
        int k;
        int frac;
        int y;
        logic [15:0] y16;
        if (!sh_enable)
            return raw;
        dl = int'(sh_delay);
        if (dl < 1)
            dl = 1;
        if (dl > DELAY_DEPTH - 1)
            dl = DELAY_DEPTH - 1;
        rd  = (int'(echo_wptr) + DELAY_DEPTH - dl) % DELAY_DEPTH;
        wet = (sh_beta > 16'd32768) ? 64'sd32768 : longint'(sh_beta);
        x   = longint'($signed(raw));
        xd  = longint'($signed(echo_mem[rd]));
        ax  = (x < 0) ? -x : x;
        acc = xd * ax * longint'($signed(sh_alpha)) * wet + (x <<< 42);
        mag = (acc < 0) ? -acc : acc;
        k   = int'(mag >> 54);
        if (k >= TANH_LAST)
            y = 32767;
        else
        begin
            frac = int'((mag >> 38) & 64'hFFFF);
            y = tanh_curve[k]
                + (((tanh_curve[k+1] - tanh_curve[k]) * frac + 32768) >>> 16);
        end
        // raw sample goes in after the read, pointer moves on
        echo_mem[echo_wptr] = raw;
        echo_wptr = echo_wptr + 1'b1;
        if (echo_wptr == '0)
            n_wraps++;
        y16 = 16'(y);
        return (acc < 0) ? -y16 : y16;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            4:       return 16'($urandom_range(0, 511)) - 16'd256;
            5:       return 16'($urandom_range(0, 8191)) - 16'd4096;
            6:       return 16'h7FFF;
            7:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------------
    task automatic feed_sample(input logic [15:0] smp, input bit typed,
                               input logic [15:0] want);
        int gap;
        logic [15:0] grown;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        grown = growl_sample(smp);
        growled_due.push_back(typed ? want : grown);
        n_sent++;
    endtask

    // stop sending and wait until every owed result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (growled_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GROWL_ENABLE: sh_enable = val[0];
            REG_GROWL_ALPHA:  sh_alpha  = val;
            REG_GROWL_BETA:   sh_beta   = val;
            REG_DELAY_LENGTH: sh_delay  = val[DLEN_W-1:0];
            default: ;
        endcase
        n_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sink side: m_tready drops in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0 && sink_stall_pct > 0
            && $urandom_range(0, 99) < sink_stall_pct)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker: each output item against the oldest owed sample
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (growled_due.size() == 0)
            begin
                $error("sample_out: expected nothing, got %0d", $signed(m_tdata));
                fails++;
            end
            else
            begin
                got_want = growled_due.pop_front();
                n_checked++;
                if (m_tdata !== got_want)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(got_want), $signed(m_tdata));
                    fails++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results owed",
                         STUCK_LIMIT, growled_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_GROWL_ENABLE;
        cfg_data       = '0;
        stall_left     = 0;
        idle_cycles    = 0;
        fails          = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_writes       = 0;
        n_wraps        = 0;
        n_random       = 0;
        send_gap_pct   = 20;
        sink_stall_pct = 20;

        // predictor after reset: memory zero, pointer zero, register defaults
        for (int i = 0; i < DELAY_DEPTH; i++)
            echo_mem[i] = '0;
        echo_wptr = '0;
        sh_enable = 1'b0;
        sh_alpha  = '0;
        sh_beta   = '0;
        sh_delay  = DLEN_W'(240);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed table ---
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                settle();
                write_reg(directed_plan[i].reg_id, directed_plan[i].value);
            end
            else
                feed_sample(directed_plan[i].value, directed_plan[i].typed,
                            directed_plan[i].want);
        end

        // --- random setting phases ---
        while (n_random < RANDOM_ITEMS)
        begin
            // per phase: off, light or heavy idling on each side
            case ($urandom_range(0, 2))
                0:       send_gap_pct = 0;
                1:       send_gap_pct = 8;
                default: send_gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_stall_pct = 0;
                1:       sink_stall_pct = 8;
                default: sink_stall_pct = 35;
            endcase
            settle();
            // enable bit with junk above it; mostly on
            write_reg(REG_GROWL_ENABLE,
                      {15'($urandom), ($urandom_range(0, 99) < 85) ? 1'b1 : 1'b0});
            case ($urandom_range(0, 4))
                0:       write_reg(REG_GROWL_ALPHA, 16'h7FFF);
                1:       write_reg(REG_GROWL_ALPHA, 16'h8000);
                2:       write_reg(REG_GROWL_ALPHA, 16'h0000);
                default: write_reg(REG_GROWL_ALPHA, 16'($urandom));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_GROWL_BETA, 16'h0000);
                1:       write_reg(REG_GROWL_BETA, 16'h8000);
                2:       write_reg(REG_GROWL_BETA, 16'($urandom_range(32769, 65535)));
                default: write_reg(REG_GROWL_BETA, 16'($urandom_range(0, 32768)));
            endcase
            // mostly short delays so reads land on fresh samples
            case ($urandom_range(0, 5))
                0:       write_reg(REG_DELAY_LENGTH, {4'($urandom), 12'd0});
                1:       write_reg(REG_DELAY_LENGTH, {4'($urandom), 12'd4095});
                2:       write_reg(REG_DELAY_LENGTH,
                                   {4'($urandom), 12'($urandom_range(1, 4095))});
                default: write_reg(REG_DELAY_LENGTH,
                                   {4'($urandom), 12'($urandom_range(1, 32))});
            endcase
            phase_len = $urandom_range(40, 160);
            repeat (phase_len)
                feed_sample(pick_sample(), CALC, '0);
            n_random += phase_len;
        end

        // --- closing run, no idling ---
        // Longest delay first, then a short one over a shorter stretch.
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        settle();
        write_reg(REG_GROWL_ENABLE, 16'h0001);
        write_reg(REG_GROWL_ALPHA, 16'($urandom));
        write_reg(REG_GROWL_BETA, 16'($urandom_range(0, 32768)));
        write_reg(REG_DELAY_LENGTH, 16'd4095);
        repeat (300)
            feed_sample(pick_sample(), CALC, '0);
        settle();
        write_reg(REG_DELAY_LENGTH, 16'($urandom_range(1, 16)));
        repeat (100)
            feed_sample(pick_sample(), CALC, '0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples (%0d results checked) over %0d register writes,",
                 n_sent, n_checked, n_writes);
        $display("growl on/off, gain and blend extremes, delay clamp, %0d pointer wrap(s)",
                 n_wraps);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dlcg_pkg.sv
rtl/core/delay_line_chaos_growl.sv
sim/delay_line_chaos_growl_test.sv
